// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset
`define PDVR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset
`define PDVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pdvr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int DIV_BITS         = 53;
    localparam logic [19:0] VEL_SCALE = 20'd1000000;
    localparam logic signed [33:0] K_Q30 = 34'sd652032875;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] z;
        logic               flip;
        logic [19:0]        dt;
    } t_entry;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;  default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Apply sign to a quotient magnitude and clamp to 32 bits
    function automatic logic [31:0] vel_sat(input logic [DIV_BITS-1:0] q,
                                            input logic neg, input logic zero);
        logic [31:0] v;
        if (zero) begin
            v = 32'd0;
        end else if (!neg) begin
            v = (q > DIV_BITS'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
        end else begin
            v = (q >= DIV_BITS'(33'h080000000)) ? 32'h80000000 : (~q[31:0] + 32'd1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pdvr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdvr_front
    import pdvr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [103:0]  i_data,
    input  wire logic          i_full,
    output      logic          o_ready,
    output      logic          o_push,
    output      t_entry        o_entry
);

    logic signed [31:0] r_prev_x, r_prev_y;
    logic signed [31:0] pos_x, pos_y;
    logic signed [32:0] z_raw;

    assign pos_x   = i_data[31:0];
    assign pos_y   = i_data[63:32];
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Difference to previous sample and yaw folded into +-90 degrees
    always_comb begin
        z_raw = {i_data[79], i_data[79:64], 16'd0};
        o_entry.dx = {pos_x[31], pos_x} - {r_prev_x[31], r_prev_x};
        o_entry.dy = {pos_y[31], pos_y} - {r_prev_y[31], r_prev_y};
        o_entry.dt = i_data[99:80];
        if (z_raw > 33'sd1073741824) begin
            o_entry.z    = 32'(z_raw - 33'sd2147483648);
            o_entry.flip = 1'b1;
        end else if (z_raw < -33'sd1073741824) begin
            o_entry.z    = 32'(z_raw + 33'sd2147483648);
            o_entry.flip = 1'b1;
        end else begin
            o_entry.z    = z_raw[31:0];
            o_entry.flip = 1'b0;
        end
    end

    // Hold the last accepted position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (o_push) begin
            r_prev_x <= pos_x;
            r_prev_y <= pos_y;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pdvr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pdvr_fifo
    import pdvr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    output      logic   o_full,
    input  wire logic   i_pop,
    output      logic   o_valid,
    output      t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rp];

    // Store a request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `PDVR_ASSERT(a_cnt_range, i_clk, i_rst_n, r_count <= 2'd2, "queue count out of range")
    `PDVR_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, i_push, r_count != 2'd2, "push into full queue")
    `PDVR_ASSERT_IMP(a_no_udf, i_clk, i_rst_n, i_pop, r_count != 2'd0, "pop from empty queue")

endmodule
`default_nettype wire

// ===== hw/rtl/pdvr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdvr_back
    import pdvr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  t_entry             i_entry,
    output      logic          o_pop,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      logic [127:0]  o_data
);

    localparam int CI_W = $clog2(CORDIC_STEPS + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           r_state;
    logic [32:0]          r_mag_x, r_mag_y;
    logic                 r_neg_x, r_neg_y, r_flip;
    logic [19:0]          r_dt;
    logic [DIV_BITS-1:0]  r_dvd_x, r_dvd_y;
    logic [19:0]          r_rem_x, r_rem_y;
    logic [5:0]           r_dcnt;
    logic signed [33:0]   r_cx, r_cy, r_cz;
    logic [CI_W-1:0]      r_ci;
    logic signed [31:0]   r_vx, r_vy;
    logic signed [63:0]   r_prod;
    logic signed [65:0]   r_acc_x, r_acc_y;
    logic [2:0]           r_rcnt;
    logic                 r_ov;
    logic [127:0]         r_out;

    logic [20:0]          sh_x, sh_y;
    logic                 ge_x, ge_y;
    logic signed [31:0]   cosv, sinv, ma, mb;
    logic signed [33:0]   cx_sh, cy_sh, at;
    logic                 cordic_busy;
    logic signed [65:0]   rnd_x, rnd_y;
    logic [31:0]          bx, by;

    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign cordic_busy = (r_ci < CI_W'(CORDIC_STEPS));

    // Divider step for both axes
    always_comb begin
        sh_x = {r_rem_x, r_dvd_x[DIV_BITS-1]};
        sh_y = {r_rem_y, r_dvd_y[DIV_BITS-1]};
        ge_x = (sh_x >= {1'b0, r_dt});
        ge_y = (sh_y >= {1'b0, r_dt});
    end

    // CORDIC shifts and table angle
    always_comb begin
        cx_sh = r_cx >>> r_ci;
        cy_sh = r_cy >>> r_ci;
        at    = {2'b00, atan_turn(5'(r_ci))};
    end

    // Rotation operands
    always_comb begin
        cosv = r_flip ? 32'(-r_cx) : r_cx[31:0];
        sinv = r_flip ? 32'(-r_cy) : r_cy[31:0];
        case (r_rcnt)
            3'd0:    begin ma = r_vx; mb = cosv; end
            3'd1:    begin ma = r_vy; mb = sinv; end
            3'd2:    begin ma = r_vx; mb = sinv; end
            default: begin ma = r_vy; mb = cosv; end
        endcase
    end

    // Round half up by 2^30 and clamp
    always_comb begin
        rnd_x = (r_acc_x + 66'sd536870912) >>> 30;
        rnd_y = (r_acc_y + 66'sd536870912) >>> 30;
        if (rnd_x > 66'sd2147483647)       bx = 32'h7FFFFFFF;
        else if (rnd_x < -66'sd2147483648) bx = 32'h80000000;
        else                               bx = rnd_x[31:0];
        if (rnd_y > 66'sd2147483647)       by = 32'h7FFFFFFF;
        else if (rnd_y < -66'sd2147483648) by = 32'h80000000;
        else                               by = rnd_y[31:0];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg_x <= i_entry.dx[32];
            r_neg_y <= i_entry.dy[32];
            r_mag_x <= i_entry.dx[32] ? 33'(-i_entry.dx) : i_entry.dx;
            r_mag_y <= i_entry.dy[32] ? 33'(-i_entry.dy) : i_entry.dy;
            r_dt    <= i_entry.dt;
            r_flip  <= i_entry.flip;
            r_cx    <= K_Q30;
            r_cy    <= '0;
            r_cz    <= {{2{i_entry.z[31]}}, i_entry.z};
            r_ci    <= '0;
        end else if (cordic_busy) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + at;
            end
            r_ci <= r_ci + CI_W'(1);
        end

        if (r_state == S_MUL) begin
            r_dvd_x <= DIV_BITS'(r_mag_x * VEL_SCALE);
            r_dvd_y <= DIV_BITS'(r_mag_y * VEL_SCALE);
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (r_state == S_DIV) begin
            if (r_dcnt != 6'd0) begin
                r_rem_x <= ge_x ? 20'(sh_x - {1'b0, r_dt}) : sh_x[19:0];
                r_rem_y <= ge_y ? 20'(sh_y - {1'b0, r_dt}) : sh_y[19:0];
                r_dvd_x <= {r_dvd_x[DIV_BITS-2:0], ge_x};
                r_dvd_y <= {r_dvd_y[DIV_BITS-2:0], ge_y};
            end else begin
                r_vx <= vel_sat(r_dvd_x, r_neg_x, r_mag_x == 33'd0);
                r_vy <= vel_sat(r_dvd_y, r_neg_y, r_mag_y == 33'd0);
            end
        end

        if (r_state == S_ROT) begin
            r_prod <= ma * mb;
            case (r_rcnt)
                3'd1:    r_acc_x <= 66'(r_prod);
                3'd2:    r_acc_x <= r_acc_x - 66'(r_prod);
                3'd3:    r_acc_y <= 66'(r_prod);
                3'd4:    r_acc_y <= r_acc_y + 66'(r_prod);
                default: ;
            endcase
        end

        if ((r_state == S_OUT) && (!r_ov || i_ready)) begin
            r_out <= {by, bx, r_vy, r_vx};
        end
    end

    // Sequence one request through multiply, divide, rotate and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcnt  <= '0;
            r_rcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // Load the output register or drop it once taken
            if ((r_state == S_OUT) && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_MUL;
                S_MUL: begin
                    r_dcnt  <= 6'(DIV_BITS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt != 6'd0) begin
                        r_dcnt <= r_dcnt - 6'd1;
                    end else if (!cordic_busy) begin
                        r_rcnt  <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_rcnt <= r_rcnt + 3'd1;
                    if (r_rcnt == 3'd4) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/position_difference_velocity_rotator.sv =====
// Finite-difference velocity with yaw rotation. Each request carries a Q16.16
// x/y position, a 16-bit binary yaw and an interval in microseconds; the block
// returns (pos - prev) * 1e6 / dt_us for both axes and that velocity rotated by
// the yaw, all saturated to 32 bits. The previous position resets to zero, so
// the first result after reset is taken against the origin. A request passes
// through setup, one multiply, a 53-bit bit-serial divider that runs both axes
// side by side while the CORDIC iterates, the rotation on one shared 32x32
// multiplier, and the output register. A two-entry queue takes up to two
// further requests while one is being worked on.
`timescale 1ns / 1ps
`default_nettype none
module position_difference_velocity_rotator
    import pdvr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output      logic          o_s_axis_tready,
    // pos_x[31:0], pos_y[63:32], yaw[79:64], dt_us[99:80], zero fill
    input  wire logic [103:0]  i_s_axis_tdata,
    output      logic          o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // vel_x[31:0], vel_y[63:32], body_vx[95:64], body_vy[127:96]
    output      logic [127:0]  o_m_axis_tdata
);

    logic   push, full, pop, q_valid;
    t_entry f_entry, q_entry;

    pdvr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_full  (full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_entry (f_entry)
    );

    pdvr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    pdvr_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/tb_position_difference_velocity_rotator.sv =====
`timescale 1ns / 1ps
module tb_position_difference_velocity_rotator;
    import pdvr_pkg::*;

    // first field in the highest bits, matching the result bus layout
    typedef struct packed {
        logic signed [31:0] body_vy;
        logic signed [31:0] body_vx;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
    } t_velocity;

    localparam int LATENCY = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // pos_x[31:0], pos_y[63:32], yaw[79:64], dt_us[99:80], zero fill
    logic [103:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // vel_x[31:0], vel_y[63:32], body_vx[95:64], body_vy[127:96]
    logic [127:0] o_m_axis_tdata;

    // predictor state: last position seen
    logic signed [63:0] last_x;
    logic signed [63:0] last_y;
    t_velocity          velocity_q[$];
    int                 mismatches;
    int                 results_seen;
    int                 requests_sent;
    int                 zero_dt_count;
    int                 saturated_count;

    position_difference_velocity_rotator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // floor shift of a signed value
    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                        input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] axis_rate(input logic signed [63:0] diff,
                                                      input logic [19:0] dt);
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        neg = diff < 0;
        mag = (neg ? -diff : diff) * 64'd1000000;
        if (dt == 0) begin
            if (diff == 0) return 0;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        q = mag / dt;
        if (q > 64'd1 << 33) q = 64'd1 << 33;
        return clamp32(neg ? -$signed(q) : $signed(q));
    endfunction

    // rotate angle folding plus shift-and-add iterations
    task automatic yaw_cos_sin(input logic signed [15:0] yaw,
                               output logic signed [63:0] c,
                               output logic signed [63:0] s);
        logic signed [63:0] z;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] nx;
        logic               flip;
        z = 64'(yaw) * 65536;
        x = 64'sd652032875;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1 <<< 30) begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - $signed({32'd0, atan_turn(5'(i))});
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + $signed({32'd0, atan_turn(5'(i))});
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_velocity(input logic [103:0] data);
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] c;
        logic signed [63:0] s;
        t_velocity          r;
        px = 64'($signed(data[31:0]));
        py = 64'($signed(data[63:32]));
        vx = axis_rate(px - last_x, data[99:80]);
        vy = axis_rate(py - last_y, data[99:80]);
        yaw_cos_sin(data[79:64], c, s);
        r.vel_x = vx[31:0];
        r.vel_y = vy[31:0];
        r.body_vx = 32'(clamp32(floor_shift(vx * c - vy * s + (64'sd1 <<< 29), 30)));
        r.body_vy = 32'(clamp32(floor_shift(vx * s + vy * c + (64'sd1 <<< 29), 30)));
        if (r.vel_x == 32'h7FFFFFFF || r.vel_x == 32'h80000000) saturated_count++;
        if (data[99:80] == 0) zero_dt_count++;
        last_x = px;
        last_y = py;
        velocity_q.push_back(r);
    endtask

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 3);
    endfunction

    // send one request and hold tvalid until accepted
    task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] yaw, input logic [19:0] dt,
                             input bit gaps);
        logic [103:0] data;
        int           gap;
        data = {4'd0, dt, yaw, py, px};
        gap = gaps ? short_or_long_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_velocity(data);
        requests_sent++;
    endtask

    // drop tvalid and hold until every expected result is back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (velocity_q.size() != 0) @(posedge i_clk);
    endtask

    // extremes of every field, zero interval, first sample after reset
    task automatic test_directed();
        send_pose(32'h7FFFFFFF, 32'h80000000, 16'h0000, 20'd1, 0);
        send_pose(32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 20'd1, 0);
        send_pose(32'h80000000, 32'h7FFFFFFF, 16'h8000, 20'd0, 0);
        send_pose(32'h00010000, 32'hFFFF0000, 16'h4000, 20'd0, 0);
        send_pose(32'h00010000, 32'hFFFF0000, 16'hC000, 20'd0, 0);
        send_pose(32'h00020000, 32'h00030000, 16'h2000, 20'hFFFFF, 0);
        send_pose(32'h00020000, 32'h00030000, 16'h4001, 20'd1000, 0);
        send_pose(32'hFFFFFFFF, 32'h00000001, 16'hBFFF, 20'd1000, 0);
        send_pose(32'h00000000, 32'h00000000, 16'h6000, 20'd3, 0);
        send_pose(32'h00001000, 32'hFFFFF000, 16'hA000, 20'd999, 0);
        send_pose(32'h40000000, 32'hC0000000, 16'hFFFF, 20'h80000, 0);
        send_pose(32'hC0000000, 32'h40000000, 16'h0001, 20'h7FFFF, 0);
        wait_drained();
    endtask

    // smooth trajectories at about 1 kHz with occasional jumps and noise
    task automatic test_random(input int count);
        logic [31:0] px;
        logic [31:0] py;
        logic [19:0] dt;
        px = $urandom;
        py = $urandom;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    px = $urandom;
                    py = $urandom;
                    dt = 20'($urandom);
                end
                1: dt = 20'd0;
                default: begin
                    px = px + 32'($signed(16'($urandom)) * $urandom_range(1, 64));
                    py = py + 32'($signed(16'($urandom)) * $urandom_range(1, 64));
                    dt = 20'($urandom_range(500, 1500));
                end
            endcase
            send_pose(px, py, 16'($urandom), dt, 1);
            if (n == count / 2) wait_drained();
        end
    endtask

    // result checker with random receiver stalls
    always @(posedge i_clk) begin
        t_velocity got;
        t_velocity want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                results_seen++;
                if (velocity_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = velocity_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %h %h %h %h got %h %h %h %h",
                                     want.vel_x, want.vel_y, want.body_vx,
                                     want.body_vy, got.vel_x, got.vel_y,
                                     got.body_vx, got.body_vy);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;
        end
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        last_x = 0;
        last_y = 0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        zero_dt_count = 0;
        saturated_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1200);
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        $display("%0d requests, %0d results, %0d zero intervals, %0d saturated",
                 requests_sent, results_seen, zero_dt_count, saturated_count);
        if (mismatches == 0 && velocity_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
